// ===== hw/rtl/epfs_pkg.sv =====
// Shared types and constants for the edge-preserving FIR smoother.
// Holds the configuration register indexes, coefficient set type and window sizes.
// No dependencies.
package epfs_pkg;

    // Coefficients are signed Q2.14 regardless of sample width
    localparam int unsigned COEF_WIDTH      = 16;

    // Window sizes and tap count
    localparam int unsigned WIN_SHORT       = 3;
    localparam int unsigned WIN_LONG        = 5;
    localparam int unsigned TAP_COUNT       = WIN_LONG;
    localparam int unsigned MAX_RESULTS     = 5;
    localparam int unsigned RES_CNT_WIDTH   = 3;

    // Element counter saturates; it only needs to say "window full"
    localparam int unsigned COUNT_WIDTH     = 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = 3'd7;
    localparam logic [COUNT_WIDTH-1:0] FULL_LONG       = COUNT_WIDTH'(WIN_LONG - 1);
    localparam logic [COUNT_WIDTH-1:0] FULL_SHORT      = COUNT_WIDTH'(WIN_SHORT - 1);

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 3;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FIVE_TAP_MODE = 3'd0,
        CFG_COEF_A        = 3'd1,
        CFG_COEF_B        = 3'd2,
        CFG_COEF_C        = 3'd3,
        CFG_COEF_D        = 3'd4,
        CFG_COEF_E        = 3'd5
    } cfg_index_t;

    // Reset value of the centre weight: 1.0 in Q2.14
    localparam logic signed [COEF_WIDTH-1:0] COEF_C_RESET = 16'sd16384;

    // Full coefficient set, offsets -2..+2 from the centre
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] c;
        logic signed [COEF_WIDTH-1:0] d;
        logic signed [COEF_WIDTH-1:0] e;
    } coef_set_t;

endpackage

// ===== hw/rtl/epfs_mac.sv =====
// Two-stage multiply-accumulate for the smoother: registered tap products,
// then sum, round half up, shift and saturate. Depends on epfs_pkg.
module epfs_mac #(
    parameter int unsigned SAMPLE_WIDTH   = 16,
    parameter int unsigned COEF_FRAC_BITS = 14
) (
    input  logic                           clk,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] taps [epfs_pkg::TAP_COUNT],
    input  epfs_pkg::coef_set_t            coefs,
    output logic signed [SAMPLE_WIDTH-1:0] result
);
    import epfs_pkg::*;

    localparam int unsigned PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int unsigned SUM_W   = PROD_W + 3;
    localparam int unsigned ACC_W   = (SUM_W > COEF_FRAC_BITS + 2) ? SUM_W : COEF_FRAC_BITS + 2;
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [COEF_WIDTH-1:0] coef_arr [TAP_COUNT];
    logic signed [PROD_W-1:0]     prod_reg [TAP_COUNT];
    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      shifted;

    assign coef_arr[0] = coefs.a;
    assign coef_arr[1] = coefs.b;
    assign coef_arr[2] = coefs.c;
    assign coef_arr[3] = coefs.d;
    assign coef_arr[4] = coefs.e;

    // Register one product per tap
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                prod_reg[i] <= PROD_W'(taps[i]) * PROD_W'(coef_arr[i]);
            end
        end
    end

    // Sum, round half up, floor shift
    always_comb
    begin
        acc = ROUND_ADD;
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        shifted = acc >>> COEF_FRAC_BITS;
    end

    // Clamp to the sample range
    always_comb
    begin
        priority if (shifted > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            result = shifted[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ===== hw/rtl/edge_preserving_fir_smoother.sv =====
// Top level of the edge-preserving FIR smoother: config registers, delay line,
// result planning and the output burst queue. Depends on epfs_pkg and epfs_mac.
//
// Smooths one array per run of input words with a 3-tap or 5-tap symmetric
// window (five_tap_mode). The pipeline is three registers deep (input, product,
// result) and takes one input word per cycle unless stalled. Each input word
// yields zero to five output words, sent one per cycle from the result register
// unless out_stall holds them; the input side stalls while a multi-word burst
// drains or while the receiver holds off, so the start of an array (head
// elements plus the first filtered element) and the word marked array_last
// (filtered element plus the tail) hold the input back while their extra words
// drain. An item's output passes through the input, product and result registers.
// Write coefficients and mode only between arrays, with the block idle.
module edge_preserving_fir_smoother #(
    parameter int unsigned SAMPLE_WIDTH   = 16,
    parameter int unsigned COEF_FRAC_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [epfs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [epfs_pkg::COEF_WIDTH-1:0]        cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample,
    input  logic                                   array_last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]         smoothed,
    output logic                                   run_last,
    output logic                                   array_end
);
    import epfs_pkg::*;

    // Configuration
    logic                          mode_reg;
    coef_set_t                     coef_reg;

    // Delay line, newest first, and element count
    logic signed [SAMPLE_WIDTH-1:0] dl_reg [4];
    logic [COUNT_WIDTH-1:0]         count_reg;

    // Input stage
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_dl_reg [4];
    logic [COUNT_WIDTH-1:0]         s1_k_reg;
    logic                           s1_mode_reg;
    logic                           s1_last_reg;

    // Plan built from the input stage
    logic signed [SAMPLE_WIDTH-1:0] plan_val [MAX_RESULTS];
    logic [RES_CNT_WIDTH-1:0]       plan_n;
    logic [RES_CNT_WIDTH-1:0]       plan_fpos;
    logic signed [SAMPLE_WIDTH-1:0] taps [TAP_COUNT];

    // Product stage
    logic                           s2_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s2_val_reg [MAX_RESULTS];
    logic [RES_CNT_WIDTH-1:0]       s2_n_reg;
    logic [RES_CNT_WIDTH-1:0]       s2_fpos_reg;
    logic                           s2_last_reg;
    logic signed [SAMPLE_WIDTH-1:0] mac_result;

    // Result burst stage
    logic                           s3_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s3_val_reg [MAX_RESULTS];
    logic [RES_CNT_WIDTH-1:0]       s3_n_reg;
    logic                           s3_last_reg;
    logic [RES_CNT_WIDTH-1:0]       s3_ptr_reg;

    // Flow control
    logic in_fire, out_fire, s3_done, s3_free, s2_move, s2_free, s3_load, s1_move;

    assign out_fire = s3_valid_reg && !out_stall;
    assign s3_done  = (s3_ptr_reg == s3_n_reg - RES_CNT_WIDTH'(1));
    assign s3_free  = !s3_valid_reg || (out_fire && s3_done);
    assign s2_move  = s2_valid_reg && ((s2_n_reg == '0) || s3_free);
    assign s3_load  = s2_move && (s2_n_reg != '0);
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_fire  = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            coef_reg.a <= '0;
            coef_reg.b <= '0;
            coef_reg.c <= COEF_C_RESET;
            coef_reg.d <= '0;
            coef_reg.e <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIVE_TAP_MODE: mode_reg   <= cfg_wdata[0];
                CFG_COEF_A:        coef_reg.a <= cfg_wdata;
                CFG_COEF_B:        coef_reg.b <= cfg_wdata;
                CFG_COEF_C:        coef_reg.c <= cfg_wdata;
                CFG_COEF_D:        coef_reg.d <= cfg_wdata;
                CFG_COEF_E:        coef_reg.e <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Advance the delay line and element count on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dl_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            dl_reg[3] <= dl_reg[2];
            dl_reg[2] <= dl_reg[1];
            dl_reg[1] <= dl_reg[0];
            dl_reg[0] <= sample;
            if (array_last)
            begin
                count_reg <= '0;
            end
            else if (count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    // Capture the word with a snapshot of the delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg    <= sample;
            s1_dl_reg   <= dl_reg;
            s1_k_reg    <= count_reg;
            s1_mode_reg <= mode_reg;
            s1_last_reg <= array_last;
        end
    end

    // Plan the result list and select the taps
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            plan_val[i] = '0;
        end
        plan_n    = '0;
        plan_fpos = '0;
        if (s1_mode_reg)
        begin
            taps[0] = s1_dl_reg[3];
            taps[1] = s1_dl_reg[2];
            taps[2] = s1_dl_reg[1];
            taps[3] = s1_dl_reg[0];
            taps[4] = s1_x_reg;
            if (s1_k_reg >= FULL_LONG)
            begin
                if (s1_k_reg == FULL_LONG)
                begin
                    // head: two pass-through elements, then filtered
                    plan_val[0] = s1_dl_reg[3];
                    plan_val[1] = s1_dl_reg[2];
                    plan_fpos   = 3'd2;
                    plan_n      = 3'd3;
                    if (s1_last_reg)
                    begin
                        plan_val[3] = s1_dl_reg[0];
                        plan_val[4] = s1_x_reg;
                        plan_n      = 3'd5;
                    end
                end
                else
                begin
                    plan_n = 3'd1;
                    if (s1_last_reg)
                    begin
                        plan_val[1] = s1_dl_reg[0];
                        plan_val[2] = s1_x_reg;
                        plan_n      = 3'd3;
                    end
                end
            end
        end
        else
        begin
            // outer taps unused in three-tap mode
            taps[0] = '0;
            taps[1] = s1_dl_reg[1];
            taps[2] = s1_dl_reg[0];
            taps[3] = s1_x_reg;
            taps[4] = '0;
            if (s1_k_reg >= FULL_SHORT)
            begin
                if (s1_k_reg == FULL_SHORT)
                begin
                    plan_val[0] = s1_dl_reg[1];
                    plan_fpos   = 3'd1;
                    plan_n      = 3'd2;
                    if (s1_last_reg)
                    begin
                        plan_val[2] = s1_x_reg;
                        plan_n      = 3'd3;
                    end
                end
                else
                begin
                    plan_n = 3'd1;
                    if (s1_last_reg)
                    begin
                        plan_val[1] = s1_x_reg;
                        plan_n      = 3'd2;
                    end
                end
            end
        end
    end

    epfs_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .load   (s1_move),
        .taps   (taps),
        .coefs  (coef_reg),
        .result (mac_result)
    );

    // Hold the plan alongside the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_val_reg  <= plan_val;
            s2_n_reg    <= plan_n;
            s2_fpos_reg <= plan_fpos;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Load a burst, then step through it one word per accepted output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_ptr_reg   <= '0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= 1'b1;
            s3_ptr_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (s3_done)
            begin
                s3_valid_reg <= 1'b0;
            end
            else
            begin
                s3_ptr_reg <= s3_ptr_reg + RES_CNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                s3_val_reg[i] <= (s2_fpos_reg == RES_CNT_WIDTH'(i)) ? mac_result
                                                                    : s2_val_reg[i];
            end
            s3_n_reg    <= s2_n_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Drive the output word
    assign out_valid = s3_valid_reg;
    assign smoothed  = s3_val_reg[s3_ptr_reg];
    assign run_last  = s3_done;
    assign array_end = s3_done && s3_last_reg;

endmodule

// ===== hw/rtl/epfs_checker.sv =====
// Port-level checker for the edge-preserving FIR smoother, bound to the top level.
// Depends on edge_preserving_fir_smoother's port names only.
module epfs_checker #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] smoothed,
    input logic                           run_last,
    input logic                           array_end
);

    // A stalled output word stays valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    // A stalled output word keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(smoothed) && $stable(run_last) && $stable(array_end))
        else $error("output payload changed while stalled");

    // The end of an array closes the burst of its input word
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && array_end |-> run_last)
        else $error("array_end without run_last");

    // With nothing waiting at the output the pipeline drains, so input never stalls
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output side is empty");

endmodule

bind edge_preserving_fir_smoother epfs_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_epfs_checker (.*);

// ===== verif/tb_edge_preserving_fir_smoother.sv =====
// Self-checking testbench for edge_preserving_fir_smoother: predicts every output word
// in software, drives arrays through the valid/stall channels and checks results in order.
// Depends on epfs_pkg and the edge_preserving_fir_smoother RTL.
module tb_edge_preserving_fir_smoother;

    timeunit 1ns;
    timeprecision 1ps;

    import epfs_pkg::*;

    localparam int unsigned SW         = 16;
    localparam int unsigned FRAC       = 14;
    localparam int          DRAIN_WAIT = 12;
    localparam int          HOLD_LEN   = 250;
    localparam longint      CYCLE_LIMIT = 500000;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
    } in_word_t;

    typedef struct {
        logic signed [SW-1:0] smoothed;
        logic                 run_last;
        logic                 array_end;
    } out_word_t;

    // DUT connections; the driven ones are known from time zero
    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        cfg_we     = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index  = '0;
    logic [COEF_WIDTH-1:0]       cfg_wdata  = '0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic signed [SW-1:0]        sample     = '0;
    logic                        array_last = 1'b0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic signed [SW-1:0]        smoothed;
    logic                        run_last;
    logic                        array_end;

    // Stimulus and scoreboard
    in_word_t  send_queue [$];
    out_word_t expected_words [$];
    int        words_pushed  = 0;
    int        words_taken   = 0;
    int        words_checked = 0;
    int        error_count   = 0;
    longint    cycle_count   = 0;
    bit        send_idle_on  = 1'b1;
    bit        recv_idle_on  = 1'b1;

    // Long receiver hold-off
    int        hold_left     = 0;
    int        hold_round    = 0;
    logic      hold_on       = 1'b0;

    // Predictor state and its copy of the registers
    logic signed [SW-1:0] tap_hist [4];
    logic [2:0]           seen_count;
    logic                 cfg_five_tap;
    coef_set_t            cfg_coef;

    edge_preserving_fir_smoother #(
        .SAMPLE_WIDTH   (SW),
        .COEF_FRAC_BITS (FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .array_last (array_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .smoothed   (smoothed),
        .run_last   (run_last),
        .array_end  (array_end)
    );

    always #5 clk = ~clk;

    // Round half up, floor shift, saturate to the sample range
    function automatic logic signed [SW-1:0] round_saturate(input longint acc);
        longint hi;
        longint lo;
        longint r;
        hi = (longint'(1) <<< (SW - 1)) - 1;
        lo = -hi - 1;
        r  = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[SW-1:0];
    endfunction

    // Work out the output words of one accepted input word and advance the window
    function automatic void smooth_step(input logic signed [SW-1:0] x, input logic last);
        out_word_t burst [5];
        int        n;
        longint    acc;
        n = 0;
        if (cfg_five_tap)
        begin
            if (seen_count >= 3'd4)
            begin
                acc = longint'(cfg_coef.a) * longint'(tap_hist[3])
                    + longint'(cfg_coef.b) * longint'(tap_hist[2])
                    + longint'(cfg_coef.c) * longint'(tap_hist[1])
                    + longint'(cfg_coef.d) * longint'(tap_hist[0])
                    + longint'(cfg_coef.e) * longint'(x);
                if (seen_count == 3'd4)
                begin
                    burst[n] = '{tap_hist[3], 1'b0, 1'b0};
                    n = n + 1;
                    burst[n] = '{tap_hist[2], 1'b0, 1'b0};
                    n = n + 1;
                end
                burst[n] = '{round_saturate(acc), 1'b0, 1'b0};
                n = n + 1;
                if (last)
                begin
                    burst[n] = '{tap_hist[0], 1'b0, 1'b0};
                    n = n + 1;
                    burst[n] = '{x, 1'b0, 1'b1};
                    n = n + 1;
                end
            end
        end
        else
        begin
            if (seen_count >= 3'd2)
            begin
                acc = longint'(cfg_coef.b) * longint'(tap_hist[1])
                    + longint'(cfg_coef.c) * longint'(tap_hist[0])
                    + longint'(cfg_coef.d) * longint'(x);
                if (seen_count == 3'd2)
                begin
                    burst[n] = '{tap_hist[1], 1'b0, 1'b0};
                    n = n + 1;
                end
                burst[n] = '{round_saturate(acc), 1'b0, 1'b0};
                n = n + 1;
                if (last)
                begin
                    burst[n] = '{x, 1'b0, 1'b1};
                    n = n + 1;
                end
            end
        end
        if (n > 0)
            burst[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.push_back(burst[i]);

        tap_hist[3] = tap_hist[2];
        tap_hist[2] = tap_hist[1];
        tap_hist[1] = tap_hist[0];
        tap_hist[0] = x;
        if (last)
            seen_count = 3'd0;
        else if (seen_count < 3'd7)
            seen_count = seen_count + 3'd1;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'sh7fff;
        if (r < 20)
            return 16'sh8000;
        if (r < 25)
            return '0;
        if (r < 30)
            return '1;
        if (r < 50)
            return SW'($signed($urandom_range(0, 600)) - 300);
        return SW'($urandom);
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'sh7fff;
        if (r < 30)
            return 16'sh8000;
        if (r < 40)
            return '0;
        if (r < 50)
            return COEF_C_RESET;
        if (r < 70)
            return COEF_WIDTH'($signed($urandom_range(0, 4096)) - 2048);
        return COEF_WIDTH'($urandom);
    endfunction

    function automatic coef_set_t rand_coef_set();
        coef_set_t c;
        c.a = rand_coef();
        c.b = rand_coef();
        c.c = rand_coef();
        c.d = rand_coef();
        c.e = rand_coef();
        return c;
    endfunction

    // Drive one register write after the next edge and mirror it in the predictor
    task automatic write_reg(input cfg_index_t idx, input logic [COEF_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_FIVE_TAP_MODE: cfg_five_tap = value[0];
            CFG_COEF_A:        cfg_coef.a   = value;
            CFG_COEF_B:        cfg_coef.b   = value;
            CFG_COEF_C:        cfg_coef.c   = value;
            CFG_COEF_D:        cfg_coef.d   = value;
            CFG_COEF_E:        cfg_coef.e   = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input logic mode, input coef_set_t c);
        write_reg(CFG_FIVE_TAP_MODE, {{(COEF_WIDTH-1){1'b0}}, mode});
        write_reg(CFG_COEF_A, c.a);
        write_reg(CFG_COEF_B, c.b);
        write_reg(CFG_COEF_C, c.c);
        write_reg(CFG_COEF_D, c.d);
        write_reg(CFG_COEF_E, c.e);
        end_writes();
    endtask

    task automatic push_word(input logic signed [SW-1:0] s, input logic last);
        send_queue.push_back('{s, last});
        words_pushed++;
    endtask

    // Hold until every pushed word is taken and every result is back, then let
    // words that cause no result clear the pipeline
    task automatic wait_drained();
        while (words_taken != words_pushed || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic push_array(input int len);
        for (int i = 0; i < len; i++)
            push_word(rand_sample(), i == len - 1);
    endtask

    // Mostly whole arrays with random content, some loose words as noise
    task automatic push_random(input int count);
        int target;
        int r;
        target = words_pushed + count;
        while (words_pushed < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push_array($urandom_range(3, 10));
            else if (r < 75)
                push_array($urandom_range(1, 4));
            else if (r < 83)
                push_array($urandom_range(20, 40));
            else
                repeat ($urandom_range(1, 4)) push_word(rand_sample(), 1'($urandom));
        end
    endtask

    // Driver: present the next pending word, hold it while stalled
    always @(posedge clk)
    begin : driver
        bit       take;
        in_word_t item;
        int       gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            take = in_valid && !in_stall;
            if (take)
            begin
                smooth_step(sample, array_last);
                words_taken++;
            end
            if (!in_valid || take)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (send_queue.size() > 0)
                begin
                    item = send_queue.pop_front();
                    sample     <= item.sample;
                    array_last <= item.last;
                    in_valid   <= 1'b1;
                    gap_left = pick_gap(send_idle_on);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Back up the block now and then so its input stalls
    always @(posedge clk)
    begin : pressure
        if (!rst_n)
        begin
            hold_left = 0;
            hold_on  <= 1'b0;
        end
        else
        begin
            if (hold_left > 0)
                hold_left--;
            else if ((hold_round == 0 && words_checked >= 100)
                     || (hold_round == 1 && words_checked >= 400))
            begin
                hold_left = HOLD_LEN;
                hold_round++;
            end
            hold_on <= (hold_left > 0);
        end
    end

    // Monitor: check each accepted word against the oldest expectation, drive stall
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        int        stall_left;
        logic      stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: smoothed=%0d run_last=%0b array_end=%0b",
                           smoothed, run_last, array_end);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (smoothed !== want.smoothed)
                    begin
                        $error("smoothed: expected %0d, actual %0d", want.smoothed, smoothed);
                        error_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
                        error_count++;
                    end
                    if (array_end !== want.array_end)
                    begin
                        $error("array_end: expected %0b, actual %0b", want.array_end, array_end);
                        error_count++;
                    end
                end
                words_checked++;
            end
            if (hold_on)
            begin
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
                stall_left = pick_gap(recv_idle_on);
            end
            out_stall <= stall_next;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        coef_set_t c;
        // predictor starts from the reset state
        for (int i = 0; i < 4; i++)
            tap_hist[i] = '0;
        seen_count   = '0;
        cfg_five_tap = 1'b1;
        cfg_coef     = '{'0, '0, COEF_C_RESET, '0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, five taps, unit centre weight: full-scale words, then a short array
        push_word(16'sh7fff, 1'b0);
        push_word(16'sh8000, 1'b0);
        push_word(16'sh0000, 1'b0);
        push_word(16'shffff, 1'b0);
        push_word(16'sh0001, 1'b1);
        push_word(16'sd5, 1'b0);
        push_word(-16'sd5, 1'b1);
        wait_drained();

        // Three taps, all weights at the top: saturate both ways, then a short array
        load_setup(1'b0, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        repeat (3) push_word(16'sh7fff, 1'b0);
        push_word(16'sh8000, 1'b0);
        push_word(16'sh8000, 1'b0);
        push_word(16'sh8000, 1'b1);
        push_word(16'sd1, 1'b0);
        push_word(16'sd2, 1'b1);
        wait_drained();

        // Tiny centre weight: round half up around zero
        load_setup(1'b0, '{16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh8000});
        push_word(16'sd8192, 1'b0);
        push_word(-16'sd8192, 1'b0);
        push_word(-16'sd8193, 1'b0);
        push_word(16'sd8191, 1'b1);
        wait_drained();

        // Switch the window in the middle of an array
        load_setup(1'b1, '{16'sh8000, 16'sh7fff, COEF_C_RESET, 16'sh7fff, 16'sh8000});
        push_word(16'sd1000, 1'b0);
        push_word(-16'sd2000, 1'b0);
        push_word(16'sd3000, 1'b0);
        wait_drained();
        write_reg(CFG_FIVE_TAP_MODE, '0);
        end_writes();
        push_word(16'sh7fff, 1'b0);
        push_word(16'sh8000, 1'b1);
        wait_drained();

        // Random phases over several settings
        load_setup(1'b1, '{16'sd1024, 16'sd4096, 16'sd6144, 16'sd4096, 16'sd1024});
        push_random(65);
        wait_drained();

        load_setup(1'b0, rand_coef_set());
        push_random(65);
        wait_drained();

        // top weights, no idling on either side
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        load_setup(1'b1, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        push_random(65);
        wait_drained();

        send_idle_on = 1'b1;
        load_setup(1'b0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        push_random(65);
        wait_drained();

        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        load_setup(1'b1, rand_coef_set());
        push_random(65);
        wait_drained();

        send_idle_on = 1'b1;
        load_setup(1'b0, '{16'sd0, 16'sd4096, 16'sd8192, 16'sd4096, 16'sd0});
        push_random(65);
        wait_drained();

        c = rand_coef_set();
        load_setup(1'($urandom), c);
        push_random(65);
        wait_drained();

        if (expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
